/* design/nearest_neighbor_ratio_edges_core_assert.svh */
// Assertion macros used by the edge finder core.
`ifndef NEAREST_NEIGHBOR_RATIO_EDGES_CORE_ASSERT_SVH
`define NEAREST_NEIGHBOR_RATIO_EDGES_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define NNRE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nnre assertion failed");

// Next-cycle implication, checked outside reset.
`define NNRE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("nnre assertion failed");

`endif

/* design/nnre_pkg.sv */
// Shared types and constants of the ratio-of-nearest edge finder.
package nnre_pkg;

    localparam int NODE_W      = 6;
    localparam int AXIS_W      = 3;
    localparam int COORD_W     = 16;
    localparam int CFG_NODES_W = 7;
    localparam int CFG_AXES_W  = 4;
    localparam int CFG_RATIO_W = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    // Parameter defaults
    localparam int MAX_NODES_DEF  = 64;
    localparam int MAX_AXES_DEF   = 8;
    localparam int COORD_BITS_DEF = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NODES = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AXES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RATIO = 2'd2;

    // Register reset values
    localparam logic [CFG_NODES_W-1:0] RST_NODES = 7'd64;
    localparam logic [CFG_AXES_W-1:0]  RST_AXES  = 4'd2;
    localparam logic [CFG_RATIO_W-1:0] RST_RATIO = 16'd1024;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    typedef struct packed {
        logic               mode;
        logic [NODE_W-1:0]  node_index;
        logic [AXIS_W-1:0]  axis_index;
        logic [COORD_W-1:0] coordinate;
    } t_in_item;

    typedef struct packed {
        logic              edge_valid;
        logic [NODE_W-1:0] edge_from;
        logic [NODE_W-1:0] edge_to;
        logic              last_edge;
    } t_out_item;

    // Control that travels with each coordinate pair through the distance unit
    typedef struct packed {
        logic              valid;
        logic              first;
        logic              last_axis;
        logic              last_node;
        logic              zero;
        logic [NODE_W-1:0] node_j;
    } t_dist_tag;

endpackage

/* design/nnre_dist_unit.sv */
// Shared squared-distance unit: absolute difference, square, accumulate over axes.
module nnre_dist_unit
    import nnre_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int DIST_W     = 2 * COORD_BITS_DEF + 3
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic [COORD_BITS-1:0] i_p,
    input  logic [COORD_BITS-1:0] i_q,
    input  t_dist_tag             i_tag,
    output logic [DIST_W-1:0]     o_dist,
    output t_dist_tag             o_tag
);

    logic [COORD_BITS-1:0]   r_diff;
    logic [2*COORD_BITS-1:0] r_sq;
    logic [DIST_W-1:0]       r_acc;
    t_dist_tag               r_tag_c;
    t_dist_tag               r_tag_d;
    t_dist_tag               r_tag_e;
    logic [COORD_BITS-1:0]   n_diff;
    t_dist_tag               n_tag_e;

    // Absolute difference; a query with no axes sees zero distance
    always_comb begin
        if (i_tag.zero) begin
            n_diff = '0;
        end else if (i_p >= i_q) begin
            n_diff = i_p - i_q;
        end else begin
            n_diff = i_q - i_p;
        end
    end

    // Payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_diff <= n_diff;
            r_sq   <= r_diff * r_diff;
            if (r_tag_d.valid) begin
                r_acc <= r_tag_d.first ? DIST_W'(r_sq) : r_acc + DIST_W'(r_sq);
            end
        end
    end

    // A distance is done once its last axis is summed
    always_comb begin
        n_tag_e       = r_tag_d;
        n_tag_e.valid = r_tag_d.valid & r_tag_d.last_axis;
    end

    // Tag stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_c <= '0;
            r_tag_d <= '0;
            r_tag_e <= '0;
        end else if (i_en) begin
            r_tag_c <= i_tag;
            r_tag_d <= r_tag_c;
            r_tag_e <= n_tag_e;
        end
    end

    assign o_dist = r_acc;
    assign o_tag  = r_tag_e;

endmodule

/* design/nearest_neighbor_ratio_edges_core.sv */
// Ratio-of-nearest edge finder: point store, query sequencer and result register.
//
//  channel  | direction | handshake                | payload
//  ---------+-----------+--------------------------+-----------------------
//  in       | input     | i_in_valid / o_in_stall  | i_in_item  (t_in_item)
//  out      | output    | o_out_valid / i_out_stall| o_out_item (t_out_item)
//  cfg      | input     | i_cfg_we                 | i_cfg_index, i_cfg_wdata
//
// A query runs two passes that issue one coordinate pair per cycle, while the
// result register is not stalled, from the two read ports of the point store
// into the one shared distance unit. Reset clears control only; the point store
// is undefined until written. A stalled result register freezes both passes and
// the closing step.
module nearest_neighbor_ratio_edges_core
    import nnre_pkg::*;
#(
    parameter int MAX_NODES  = MAX_NODES_DEF,
    parameter int MAX_AXES   = MAX_AXES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_item              i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_item,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    `include "nearest_neighbor_ratio_edges_core_assert.svh"

    localparam int DEPTH   = MAX_NODES * MAX_AXES;
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int XW      = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int DIST_W  = 2 * COORD_BITS + $clog2(MAX_AXES);
    localparam int BOUND_W = DIST_W + CFG_RATIO_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_PASS1  = 3'd1;
    localparam logic [2:0] ST_BOUND  = 3'd2;
    localparam logic [2:0] ST_PASS2  = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;

    logic [COORD_BITS-1:0]  r_mem [DEPTH];
    logic [COORD_BITS-1:0]  r_rd_p;
    logic [COORD_BITS-1:0]  r_rd_q;
    t_dist_tag              r_tag_b;

    logic [CFG_NODES_W-1:0] r_cfg_nodes;
    logic [CFG_AXES_W-1:0]  r_cfg_axes;
    logic [CFG_RATIO_W-1:0] r_cfg_ratio;

    logic [2:0]             r_state;
    logic [NODE_W-1:0]      r_node;
    logic [CFG_NODES_W-1:0] r_n;
    logic [CFG_AXES_W-1:0]  r_axes;
    logic                   r_zero;
    logic [NODE_W-1:0]      r_j_start;
    logic [NODE_W-1:0]      r_j;
    logic [XW-1:0]          r_x;
    logic                   r_issue_done;
    logic [DIST_W-1:0]      r_best;
    logic                   r_have_best;
    logic [BOUND_W-1:0]     r_bound;
    logic                   r_pend_valid;
    logic [NODE_W-1:0]      r_pend_to;
    logic                   r_out_valid;
    t_out_item              r_out_item;

    logic                   w_accept;
    logic                   w_adv;
    logic                   w_issue;
    logic                   w_last_axis;
    logic [CFG_NODES_W-1:0] w_j_inc;
    logic [CFG_NODES_W-1:0] w_j_next;
    logic                   w_last_node;
    logic [AW-1:0]          w_addr_p;
    logic [AW-1:0]          w_addr_q;
    logic [AW-1:0]          w_addr_wr;
    logic                   w_wr_en;
    logic [COORD_BITS+COORD_W-1:0] w_coord_ext;
    t_dist_tag              w_tag_a;
    logic [DIST_W-1:0]      w_dist;
    t_dist_tag              w_tag_e;
    logic                   w_pass;
    logic [CFG_NODES_W-1:0] w_n_eff;
    logic [CFG_AXES_W-1:0]  w_axes_eff;
    logic                   w_empty;
    logic                   w_load;
    t_out_item              w_load_item;

    // Handshakes: take items only when idle; freeze when the result is stuck
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_adv      = !r_out_valid || !i_out_stall;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_nodes <= RST_NODES;
            r_cfg_axes  <= RST_AXES;
            r_cfg_ratio <= RST_RATIO;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_NODES: r_cfg_nodes <= i_cfg_wdata[CFG_NODES_W-1:0];
                REG_AXES:  r_cfg_axes  <= i_cfg_wdata[CFG_AXES_W-1:0];
                REG_RATIO: r_cfg_ratio <= i_cfg_wdata[CFG_RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Point store write path
    assign w_coord_ext = {COORD_BITS'(0), i_in_item.coordinate};
    assign w_wr_en     = w_accept && (i_in_item.mode == MODE_WRITE)
                         && ({1'b0, i_in_item.node_index} < 7'(MAX_NODES))
                         && ({1'b0, i_in_item.axis_index} < 4'(MAX_AXES));
    assign w_addr_wr   = AW'(32'(i_in_item.node_index) * 32'(MAX_AXES)
                             + 32'(i_in_item.axis_index));

    // Point store read ports, registered
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_addr_wr] <= w_coord_ext[COORD_BITS-1:0];
        end
        if (w_adv) begin
            r_rd_p <= r_mem[w_addr_p];
            r_rd_q <= r_mem[w_addr_q];
        end
    end

    // Clamp the query limits
    always_comb begin
        w_n_eff = (r_cfg_nodes > 7'(MAX_NODES)) ? 7'(MAX_NODES) : r_cfg_nodes;
        if (r_cfg_axes == '0) begin
            w_axes_eff = 4'd1;
        end else if (r_cfg_axes > 4'(MAX_AXES)) begin
            w_axes_eff = 4'(MAX_AXES);
        end else begin
            w_axes_eff = r_cfg_axes;
        end
        w_empty = (w_n_eff < 7'd2) || ({1'b0, i_in_item.node_index} >= w_n_eff);
    end

    // Issue one coordinate pair per cycle unless the result is stuck, skipping the queried node
    always_comb begin
        w_issue     = w_adv && !r_issue_done
                      && ((r_state == ST_PASS1) || (r_state == ST_PASS2));
        w_last_axis = (4'(r_x) == r_axes - 4'd1);
        w_j_inc     = {1'b0, r_j} + 7'd1;
        w_j_next    = (w_j_inc == {1'b0, r_node}) ? w_j_inc + 7'd1 : w_j_inc;
        w_last_node = w_last_axis && (w_j_next >= r_n);
        w_addr_p    = AW'(32'(r_node) * 32'(MAX_AXES) + 32'(r_x));
        w_addr_q    = AW'(32'(r_j) * 32'(MAX_AXES) + 32'(r_x));
        w_tag_a.valid     = w_issue;
        w_tag_a.first     = (r_x == '0);
        w_tag_a.last_axis = w_last_axis;
        w_tag_a.last_node = w_last_node;
        w_tag_a.zero      = r_zero;
        w_tag_a.node_j    = r_j;
    end

    // Tag stage aligned with the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_b <= '0;
        end else if (w_adv) begin
            r_tag_b <= w_tag_a;
        end
    end

    nnre_dist_unit #(
        .COORD_BITS (COORD_BITS),
        .DIST_W     (DIST_W)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_p     (r_rd_p),
        .i_q     (r_rd_q),
        .i_tag   (r_tag_b),
        .o_dist  (w_dist),
        .o_tag   (w_tag_e)
    );

    // Ratio test: d2 * 256 <= ratio * nearest, exact
    assign w_pass = (BOUND_W'({w_dist, 8'd0}) <= r_bound);

    // Result load: a held edge when a newer one passes, or the closing item
    always_comb begin
        w_load      = 1'b0;
        w_load_item = '0;
        w_load_item.edge_from = r_node;
        if (w_adv && (r_state == ST_PASS2) && w_tag_e.valid && w_pass && r_pend_valid) begin
            w_load                = 1'b1;
            w_load_item.edge_valid = 1'b1;
            w_load_item.edge_to    = r_pend_to;
        end else if (w_adv && (r_state == ST_FINISH)) begin
            w_load                 = 1'b1;
            w_load_item.edge_valid = r_pend_valid;
            w_load_item.edge_to    = r_pend_valid ? r_pend_to : '0;
            w_load_item.last_edge  = 1'b1;
        end
    end

    // Query sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_issue_done <= 1'b0;
            r_have_best  <= 1'b0;
            r_pend_valid <= 1'b0;
            r_best       <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_accept && (i_in_item.mode == MODE_QUERY)) begin
                        r_node       <= i_in_item.node_index;
                        r_n          <= w_n_eff;
                        r_axes       <= w_axes_eff;
                        r_zero       <= (r_cfg_axes == '0);
                        r_j_start    <= (i_in_item.node_index == '0) ? NODE_W'(1) : '0;
                        r_j          <= (i_in_item.node_index == '0) ? NODE_W'(1) : '0;
                        r_x          <= '0;
                        r_issue_done <= 1'b0;
                        r_have_best  <= 1'b0;
                        r_pend_valid <= 1'b0;
                        r_state      <= w_empty ? ST_FINISH : ST_PASS1;
                    end
                end
                ST_PASS1, ST_PASS2: begin
                    if (w_issue) begin
                        r_x <= w_last_axis ? '0 : r_x + XW'(1);
                        if (w_last_axis) begin
                            r_j <= w_j_next[NODE_W-1:0];
                        end
                        if (w_last_node) begin
                            r_issue_done <= 1'b1;
                        end
                    end
                    if (w_adv && w_tag_e.valid) begin
                        if (r_state == ST_PASS1) begin
                            if (!r_have_best || (w_dist < r_best)) begin
                                r_best <= w_dist;
                            end
                            r_have_best <= 1'b1;
                            if (w_tag_e.last_node) begin
                                r_state <= ST_BOUND;
                            end
                        end else begin
                            if (w_pass) begin
                                r_pend_valid <= 1'b1;
                                r_pend_to    <= w_tag_e.node_j;
                            end
                            if (w_tag_e.last_node) begin
                                r_state <= ST_FINISH;
                            end
                        end
                    end
                end
                ST_BOUND: begin
                    r_bound      <= BOUND_W'(r_cfg_ratio) * BOUND_W'(r_best);
                    r_j          <= r_j_start;
                    r_x          <= '0;
                    r_issue_done <= 1'b0;
                    r_state      <= ST_PASS2;
                end
                ST_FINISH: begin
                    if (w_adv) begin
                        r_pend_valid <= 1'b0;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_item <= w_load_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // A non-final edge means the query is still running
    `NNRE_ASSERT_IMPL(a_open_query, o_out_valid && !o_out_item.last_edge, r_state != ST_IDLE)
    // The empty answer always closes its query
    `NNRE_ASSERT_IMPL(a_empty_last, o_out_valid && !o_out_item.edge_valid, o_out_item.last_edge)
    // No edge points back at the queried node
    `NNRE_ASSERT_IMPL(a_no_self, o_out_valid && o_out_item.edge_valid,
                      o_out_item.edge_to != o_out_item.edge_from)
    // The second pass always has a nearest distance to test against
    `NNRE_ASSERT_IMPL(a_best_ready, r_state == ST_PASS2, r_have_best)
    // Leaving the closing step clears the held edge
    `NNRE_ASSERT_NEXT(a_pend_clear, (r_state == ST_FINISH) && w_adv, !r_pend_valid)

endmodule
